@@ design/bge_pkg.sv @@
package bge_pkg;

  localparam int GLYPH_WIDTH      = 8;
  localparam int GLYPH_HEIGHT_DEF = 8;
  localparam int GLYPH_COUNT_DEF  = 256;

  localparam int FONT_ADDR_W = 11;
  localparam int CODE_W      = 8;
  localparam int COORD_W     = 16;
  localparam int PIX_W       = 17;
  localparam int COLOR_W     = 32;
  localparam int COL_W       = $clog2(GLYPH_WIDTH);
  localparam int CFG_IDX_W   = 3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 3'd5;

  localparam logic [COLOR_W-1:0]        FG_RESET   = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0]        BG_RESET   = 32'h0000_0000;
  localparam logic signed [COORD_W-1:0] CLIP_LO_RESET = 16'sd0;
  localparam logic signed [COORD_W-1:0] CLIP_HI_RESET = 16'sd32767;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } bge_state_t;

endpackage

@@ design/bge_ram.sv @@
module bge_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/bitmap_glyph_expander_8x8_core.sv @@
// Opaque 8-pixel-wide glyph renderer with an on-chip font store.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the
// foreground and background colors and the clip rectangle; cfg_ready is always
// high and a write takes effect on the transfer edge.
// Input channel (in_*): func 0 writes one font byte into the store and yields
// no pixel; func 1 draws the glyph of in_char_code with its top-left corner
// at (in_pos_x, in_pos_y).
// Output channel (out_*): one pixel per transfer, row by row, leftmost pixel
// first, with its coordinates, color, clip flag and a last flag on the final
// pixel of the glyph.
// A draw first reads the first glyph row from the font memory, then loads it
// into the row shift register (ST_LOAD), then emits one pixel per cycle while
// the receiver is ready. The single read port of the font memory fetches the
// next row while the current row is shifted out. The first pixel is registered
// into the output register in the emit state (ST_EMIT), after the load state.
// A new item is accepted once the previous draw has handed its last pixel to
// the output register. A stalled receiver holds the output register and
// freezes the pixel walk.
// Reset restores the register defaults and empties the output register; the
// font store is not cleared and must be loaded before glyphs are drawn.
module bitmap_glyph_expander_8x8_core
  import bge_pkg::*;
#(
  parameter int GLYPH_HEIGHT = GLYPH_HEIGHT_DEF,
  parameter int GLYPH_COUNT  = GLYPH_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COLOR_W-1:0]          cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [FONT_ADDR_W-1:0]      in_font_address,
  input  logic [7:0]                  in_font_byte,
  input  logic [CODE_W-1:0]           in_char_code,
  input  logic signed [COORD_W-1:0]   in_pos_x,
  input  logic signed [COORD_W-1:0]   in_pos_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [PIX_W-1:0]     out_pixel_x,
  output logic signed [PIX_W-1:0]     out_pixel_y,
  output logic [COLOR_W-1:0]          out_color,
  output logic                        out_visible,
  output logic                        out_last
);

  localparam int FONT_SPACE  = 2 ** FONT_ADDR_W;
  localparam int FULL_DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int STORE_DEPTH = (FULL_DEPTH < FONT_SPACE) ? FULL_DEPTH : FONT_SPACE;
  localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int FA_W        = (FULL_DEPTH > 1) ? $clog2(FULL_DEPTH) : 1;
  localparam int ROW_W       = $clog2(GLYPH_HEIGHT + 2);
  localparam int CODES       = 2 ** CODE_W;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_HEIGHT - 1);
  localparam logic [ROW_W-1:0] HEIGHT_R = ROW_W'(GLYPH_HEIGHT);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_WIDTH - 1);

  // code wrap table
  logic [CODE_W-1:0] mod_tbl [CODES];

  for (genvar gi = 0; gi < CODES; gi++) begin : g_mod
    localparam int CM = gi % GLYPH_COUNT;
    assign mod_tbl[gi] = CODE_W'(CM);
  end

  bge_state_t state_r, state_nxt;

  logic [COLOR_W-1:0]        fg_r, bg_r;
  logic signed [COORD_W-1:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;

  logic [FA_W-1:0]           base_r;
  logic signed [COORD_W-1:0] pos_x_r, pos_y_r;
  logic [ROW_W-1:0]          row_r;
  logic [COL_W-1:0]          col_r;
  logic [GLYPH_WIDTH-1:0]    row_bits_r;

  logic                      out_valid_r;
  logic signed [PIX_W-1:0]   pixel_x_r, pixel_y_r;
  logic [COLOR_W-1:0]        color_r;
  logic                      visible_r, last_r;

  logic                      in_xfer, draw_xfer, adv, row_end, glyph_end;
  logic [FA_W-1:0]           base_calc;
  logic [FA_W-1:0]           fetch_addr;
  logic [ROW_W-1:0]          fetch_row;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             rd_addr;
  logic [GLYPH_WIDTH-1:0]    rd_data;
  logic signed [PIX_W-1:0]   px_calc, py_calc;
  logic                      vis_calc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign draw_xfer = in_xfer && (in_func == FUNC_DRAW);
  assign wr_en     = in_xfer && (in_func == FUNC_LOAD) &&
                     ({1'b0, in_font_address} < (FONT_ADDR_W + 1)'(STORE_DEPTH));

  assign base_calc = FA_W'(32'(mod_tbl[in_char_code]) * GLYPH_HEIGHT);

  assign adv       = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign row_end   = (col_r == LAST_COL);
  assign glyph_end = row_end && (row_r == LAST_ROW);

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    fetch_row = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (draw_xfer) begin
          rd_en     = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        fetch_row = ROW_W'(1);
        rd_en     = (fetch_row < HEIGHT_R);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        fetch_row = row_r + ROW_W'(2);
        if (adv && row_end) begin
          rd_en = (fetch_row < HEIGHT_R);
          if (glyph_end) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign fetch_addr = (state_r == ST_IDLE) ? base_calc : base_r + FA_W'(fetch_row);
  assign rd_addr    = fetch_addr[AW-1:0];

  bge_ram #(
    .WIDTH  (GLYPH_WIDTH),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (AW)
  ) u_font (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_font_address[AW-1:0]),
    .wr_data (in_font_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign px_calc  = PIX_W'(pos_x_r) + PIX_W'(col_r);
  assign py_calc  = PIX_W'(pos_y_r) + PIX_W'(row_r);
  assign vis_calc = ($signed(px_calc) >= $signed(PIX_W'(clip_left_r)))  &&
                    ($signed(px_calc) <  $signed(PIX_W'(clip_right_r))) &&
                    ($signed(py_calc) >= $signed(PIX_W'(clip_top_r)))   &&
                    ($signed(py_calc) <  $signed(PIX_W'(clip_bottom_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      row_r         <= '0;
      col_r         <= '0;
      fg_r          <= FG_RESET;
      bg_r          <= BG_RESET;
      clip_left_r   <= CLIP_LO_RESET;
      clip_top_r    <= CLIP_LO_RESET;
      clip_right_r  <= CLIP_HI_RESET;
      clip_bottom_r <= CLIP_HI_RESET;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FG_COLOR:    fg_r          <= cfg_data;
          CFG_BG_COLOR:    bg_r          <= cfg_data;
          CFG_CLIP_LEFT:   clip_left_r   <= cfg_data[COORD_W-1:0];
          CFG_CLIP_TOP:    clip_top_r    <= cfg_data[COORD_W-1:0];
          CFG_CLIP_RIGHT:  clip_right_r  <= cfg_data[COORD_W-1:0];
          CFG_CLIP_BOTTOM: clip_bottom_r <= cfg_data[COORD_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_r == ST_LOAD) begin
        row_r <= '0;
        col_r <= '0;
      end else if (adv) begin
        if (row_end) begin
          row_r <= row_r + ROW_W'(1);
        end
        col_r <= col_r + COL_W'(1);
      end

      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw_xfer) begin
      base_r  <= base_calc;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
    end
    if (state_r == ST_LOAD) begin
      row_bits_r <= rd_data;
    end else if (adv) begin
      row_bits_r <= row_end ? rd_data : {row_bits_r[GLYPH_WIDTH-2:0], 1'b0};
    end
    if (adv) begin
      pixel_x_r <= px_calc;
      pixel_y_r <= py_calc;
      color_r   <= row_bits_r[GLYPH_WIDTH-1] ? fg_r : bg_r;
      visible_r <= vis_calc;
      last_r    <= glyph_end;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = pixel_x_r;
  assign out_pixel_y = pixel_y_r;
  assign out_color   = color_r;
  assign out_visible = visible_r;
  assign out_last    = last_r;

`ifndef NO_ASSERTIONS
  a_draw_starts_load: assert property (@(posedge clk) disable iff (!rst_n)
    draw_xfer |=> (state_r == ST_LOAD))
    else $error("draw transfer did not start a row load");

  a_load_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |=> (state_r == ST_EMIT))
    else $error("row load not followed by pixel walk");

  a_glyph_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && glyph_end) |=> (state_r == ST_IDLE) && out_valid_r && last_r)
    else $error("final pixel did not end the walk");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_IDLE) && !rd_en)
    else $error("font write outside idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready) || !$past(rst_n))
    else $error("pixel dropped without transfer");
`endif

endmodule

@@ tb/bge_pixel_checker.sv @@
`timescale 1ns / 100ps

module bge_pixel_checker
  import bge_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COLOR_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      in_func,
  input  logic [FONT_ADDR_W-1:0]    in_font_address,
  input  logic [7:0]                in_font_byte,
  input  logic [CODE_W-1:0]         in_char_code,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [PIX_W-1:0]   out_pixel_x,
  input  logic signed [PIX_W-1:0]   out_pixel_y,
  input  logic [COLOR_W-1:0]        out_color,
  input  logic                      out_visible,
  input  logic                      out_last,
  output int                        mismatches,
  output int                        pending
);

  localparam int ROWS        = GLYPH_HEIGHT_DEF;
  localparam int STORE_DEPTH = GLYPH_COUNT_DEF * ROWS;
  localparam int GLYPH_PIXELS = GLYPH_WIDTH * ROWS;

  typedef struct packed {
    logic signed [PIX_W-1:0] x;
    logic signed [PIX_W-1:0] y;
    logic [COLOR_W-1:0]      color;
    logic                    visible;
    logic                    last;
  } pixel_t;

  logic [7:0]                font_copy [STORE_DEPTH];
  logic [COLOR_W-1:0]        fg_color;
  logic [COLOR_W-1:0]        bg_color;
  logic signed [COORD_W-1:0] clip_left;
  logic signed [COORD_W-1:0] clip_top;
  logic signed [COORD_W-1:0] clip_right;
  logic signed [COORD_W-1:0] clip_bottom;
  pixel_t                    pixels_due [$];
  int                        pixels_seen;

  initial begin
    mismatches = 0;
    pending = 0;
    pixels_seen = 0;
  end

  task automatic expand_glyph(input logic [CODE_W-1:0] code,
                              input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py);
    int     row;
    int     col;
    int     x;
    int     y;
    logic [7:0] bits;
    pixel_t p;
    for (int n = 0; n < GLYPH_PIXELS; n++) begin
      row  = n / GLYPH_WIDTH;
      col  = n % GLYPH_WIDTH;
      bits = font_copy[(int'(code) % GLYPH_COUNT_DEF) * ROWS + row];
      x    = int'(px) + col;
      y    = int'(py) + row;
      p.x       = PIX_W'(x);
      p.y       = PIX_W'(y);
      p.color   = bits[GLYPH_WIDTH-1-col] ? fg_color : bg_color;
      p.visible = (x >= int'(clip_left)) && (x < int'(clip_right)) &&
                  (y >= int'(clip_top)) && (y < int'(clip_bottom));
      p.last    = (n == GLYPH_PIXELS - 1);
      pixels_due.push_back(p);
    end
  endtask

  task automatic flag_pixel(input string why, input pixel_t want, input pixel_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t pixel %0d %s: expected x=%0d y=%0d color=%h visible=%b last=%b, got x=%0d y=%0d color=%h visible=%b last=%b",
               $time, pixels_seen, why, want.x, want.y, want.color, want.visible,
               want.last, got.x, got.y, got.color, got.visible, got.last);
  endtask

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      fg_color    = FG_RESET;
      bg_color    = BG_RESET;
      clip_left   = CLIP_LO_RESET;
      clip_top    = CLIP_LO_RESET;
      clip_right  = CLIP_HI_RESET;
      clip_bottom = CLIP_HI_RESET;
      pixels_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.x       = out_pixel_x;
        got.y       = out_pixel_y;
        got.color   = out_color;
        got.visible = out_visible;
        got.last    = out_last;
        if (pixels_due.size() == 0) begin
          flag_pixel("with none due", '0, got);
        end else begin
          want = pixels_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.visible !== want.visible || got.last !== want.last)
            flag_pixel("mismatch", want, got);
        end
        pixels_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FG_COLOR:    fg_color = cfg_data;
          CFG_BG_COLOR:    bg_color = cfg_data;
          CFG_CLIP_LEFT:   clip_left = cfg_data[COORD_W-1:0];
          CFG_CLIP_TOP:    clip_top = cfg_data[COORD_W-1:0];
          CFG_CLIP_RIGHT:  clip_right = cfg_data[COORD_W-1:0];
          CFG_CLIP_BOTTOM: clip_bottom = cfg_data[COORD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_LOAD)
          font_copy[in_font_address] = in_font_byte;
        else
          expand_glyph(in_char_code, in_pos_x, in_pos_y);
      end
    end
    pending <= pixels_due.size();
  end

endmodule

@@ tb/bitmap_glyph_expander_8x8_core_tb.sv @@
`timescale 1ns / 100ps

module bitmap_glyph_expander_8x8_core_tb
  import bge_pkg::*;
;

  localparam int STORE_DEPTH = GLYPH_COUNT_DEF * GLYPH_HEIGHT_DEF;
  localparam int LONG_STALL  = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN       = 80;
  localparam int PHASE_ITEMS = 41;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COLOR_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_func = FUNC_LOAD;
  logic [FONT_ADDR_W-1:0]    in_font_address = '0;
  logic [7:0]                in_font_byte = '0;
  logic [CODE_W-1:0]         in_char_code = '0;
  logic signed [COORD_W-1:0] in_pos_x = '0;
  logic signed [COORD_W-1:0] in_pos_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [PIX_W-1:0]   out_pixel_x;
  logic signed [PIX_W-1:0]   out_pixel_y;
  logic [COLOR_W-1:0]        out_color;
  logic                      out_visible;
  logic                      out_last;
  int                        mismatches;
  int                        pending;

  bit                        font_loaded [STORE_DEPTH];
  logic signed [COORD_W-1:0] clip_l = CLIP_LO_RESET;
  logic signed [COORD_W-1:0] clip_t = CLIP_LO_RESET;
  logic signed [COORD_W-1:0] clip_r = CLIP_HI_RESET;
  logic signed [COORD_W-1:0] clip_b = CLIP_HI_RESET;
  int                        burst_left = 0;
  int                        items_sent = 0;
  logic                      stall_req = 1'b0;
  logic                      stall_taken = 1'b0;
  int                        stall_left = 0;
  int                        rx_mode = 0;
  int                        rx_mode_left = 0;
  int                        quiet_cycles = 0;

  bitmap_glyph_expander_8x8_core dut (.*);

  bge_pixel_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_req && !stall_taken) begin
      stall_taken = 1'b1;
      stall_left = LONG_STALL;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(16, 160);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("bitmap_glyph_expander_8x8_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic func, input logic [FONT_ADDR_W-1:0] addr,
                           input logic [7:0] fbyte, input logic [CODE_W-1:0] code,
                           input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_func         <= func;
    in_font_address <= addr;
    in_font_byte    <= fbyte;
    in_char_code    <= code;
    in_pos_x        <= px;
    in_pos_y        <= py;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic load_byte(input logic [FONT_ADDR_W-1:0] addr, input logic [7:0] fbyte);
    push_item(FUNC_LOAD, addr, fbyte, CODE_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom));
    font_loaded[addr] = 1'b1;
  endtask

  task automatic draw_glyph(input logic [CODE_W-1:0] code,
                            input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    push_item(FUNC_DRAW, FONT_ADDR_W'($urandom), 8'($urandom), code, px, py);
  endtask

  task automatic load_glyph(input logic [CODE_W-1:0] code, input int rows);
    logic [7:0] fbyte;
    for (int r = 0; r < rows; r++) begin
      case ($urandom_range(0, 5))
        0: fbyte = 8'h00;
        1: fbyte = 8'hFF;
        default: fbyte = 8'($urandom);
      endcase
      load_byte(FONT_ADDR_W'(int'(code) * GLYPH_HEIGHT_DEF + r), fbyte);
    end
  endtask

  function automatic bit glyph_ready(input logic [CODE_W-1:0] code);
    for (int r = 0; r < GLYPH_HEIGHT_DEF; r++)
      if (!font_loaded[int'(code) * GLYPH_HEIGHT_DEF + r]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [CODE_W-1:0] pick_ready_code();
    logic [CODE_W-1:0] code;
    for (int k = 0; k < 32; k++) begin
      code = CODE_W'($urandom);
      if (glyph_ready(code)) return code;
    end
    return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] lo_bound, input logic signed [COORD_W-1:0] hi_bound);
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom);
      1: return COORD_W'(int'(lo_bound) + $urandom_range(0, 15) - 8);
      2: return COORD_W'(int'(hi_bound) + $urandom_range(0, 15) - 8);
      default: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    endcase
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_regs(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                          input logic signed [COORD_W-1:0] l,
                          input logic signed [COORD_W-1:0] t,
                          input logic signed [COORD_W-1:0] r,
                          input logic signed [COORD_W-1:0] b, input bit spare);
    settle();
    write_reg(CFG_FG_COLOR, fg);
    write_reg(CFG_BG_COLOR, bg);
    write_reg(CFG_CLIP_LEFT, {16'($urandom), l});
    write_reg(CFG_CLIP_TOP, {16'($urandom), t});
    write_reg(CFG_CLIP_RIGHT, {16'($urandom), r});
    write_reg(CFG_CLIP_BOTTOM, {16'($urandom), b});
    if (spare) begin
      write_reg(CFG_SPARE_LO, $urandom);
      write_reg(CFG_SPARE_HI, $urandom);
    end
    cfg_valid <= 1'b0;
    clip_l = l;
    clip_t = t;
    clip_r = r;
    clip_b = b;
  endtask

  task automatic random_phase(input int count);
    int goal;
    logic [CODE_W-1:0] code;
    goal = items_sent + count;
    while (items_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          code = CODE_W'($urandom);
          load_glyph(code, GLYPH_HEIGHT_DEF);
          draw_glyph(code, pick_coord(clip_l, clip_r), pick_coord(clip_t, clip_b));
        end
        5, 6, 7: draw_glyph(pick_ready_code(), pick_coord(clip_l, clip_r),
                            pick_coord(clip_t, clip_b));
        8: load_byte(FONT_ADDR_W'($urandom), 8'($urandom));
        default: load_glyph(CODE_W'($urandom), $urandom_range(1, GLYPH_HEIGHT_DEF - 1));
      endcase
    end
  endtask

  initial begin
    logic signed [COORD_W-1:0] win_x;
    logic signed [COORD_W-1:0] win_y;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    load_byte(11'd0, 8'h80);
    load_byte(11'd1, 8'h01);
    load_byte(11'd2, 8'hFF);
    load_byte(11'd3, 8'h00);
    load_byte(11'd4, 8'hAA);
    load_byte(11'd5, 8'h55);
    load_byte(11'd6, 8'h3C);
    load_byte(11'd7, 8'hC3);
    load_byte(11'd2040, 8'h01);
    load_byte(11'd2041, 8'h80);
    load_byte(11'd2042, 8'h00);
    load_byte(11'd2043, 8'hFF);
    load_byte(11'd2044, 8'h55);
    load_byte(11'd2045, 8'hAA);
    load_byte(11'd2046, 8'hC3);
    load_byte(11'd2047, 8'h3C);
    draw_glyph(8'd0, 16'sd0, 16'sd0);
    draw_glyph(8'd255, 16'sh7FFF, 16'sh7FFF);
    draw_glyph(8'd0, 16'sh8000, 16'sh8000);
    draw_glyph(8'd255, -16'sd4, -16'sd3);
    draw_glyph(8'd0, 16'sd32762, 16'sd32760);

    set_regs(32'h0000_0000, 32'hFFFF_FFFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
             1'b1);
    stall_req <= 1'b1;
    random_phase(PHASE_ITEMS);

    set_regs($urandom, $urandom, 16'sh7FFF, 16'sd5, 16'sh8000, 16'sd5, 1'b0);
    random_phase(PHASE_ITEMS);

    win_x = COORD_W'($urandom);
    win_y = COORD_W'($urandom);
    set_regs($urandom, $urandom, win_x, win_y, COORD_W'(int'(win_x) + $urandom_range(1, 40)),
             COORD_W'(int'(win_y) + $urandom_range(1, 40)), 1'b0);
    random_phase(PHASE_ITEMS);

    repeat (4) begin
      set_regs($urandom, $urandom, COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom), 1'b0);
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0 && pending == 0)
      $display("bitmap_glyph_expander_8x8_core regression: pass");
    else
      $display("bitmap_glyph_expander_8x8_core regression: fail");
    $finish;
  end

endmodule
